### rtl/core/stk_pkg.sv
package stk_pkg;

   localparam int POSITION_BITS_DEFAULT = 32;
   localparam int RECS_PER_ITEM = 4;
   localparam int REC_COUNT_BITS = $clog2(RECS_PER_ITEM + 1);
   localparam int REC_INDEX_BITS = $clog2(RECS_PER_ITEM);
   localparam logic [15:0] ERROR_LIMIT_RESET = 16'd10;

   typedef enum logic [3:0] {
      KIND_IDENT    = 4'd0,
      KIND_NUMBER   = 4'd1,
      KIND_STRING   = 4'd2,
      KIND_COLON    = 4'd3,
      KIND_SCOPE    = 4'd4,
      KIND_PLUS     = 4'd5,
      KIND_MINUS    = 4'd6,
      KIND_STAR     = 4'd7,
      KIND_SLASH    = 4'd8,
      KIND_LBRACKET = 4'd9,
      KIND_RBRACKET = 4'd10,
      KIND_SEMI_ERR = 4'd11,
      KIND_CHAR_ERR = 4'd12,
      KIND_FRAC_ERR = 4'd13,
      KIND_UNTERM   = 4'd14,
      KIND_END      = 4'd15
   } kind_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] start_offset;
      logic [31:0] lexeme_length;
      logic [31:0] line_number;
      logic        any_error;
      logic        aborted;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      rsp_type [RECS_PER_ITEM-1:0] rec;
      logic [REC_COUNT_BITS-1:0]   count;
   } batch_type;

endpackage

### rtl/core/source_tokenizer.sv
// Streaming source lexer, one source byte per request.
// req channel: char_code plus end_of_file on the final byte of a file.
// rsp channel: token, error and end records, up to four per request; last_of_run
//   marks the final record caused by a request. Requests causing no record
//   (blanks, token bytes still extending a token) produce nothing on rsp.
// csr channel: writes error_limit (reset value 10), always ready; write only
//   while the block is idle.
// Output: records of an accepted request are registered into the batch buffer
//   behind earlier ones; they follow one per cycle while rsp_ready is high.
// Throughput: one request per cycle while each yields at most one record and
//   rsp_ready stays high; the output drains one record per cycle while rsp_ready
//   is high. The scan state (mode, token start, offset, line, error tally) is
//   registered and updated once per accepted byte.
// Stall: records are held in a two-request batch buffer; req_ready drops only
//   when both batches are occupied, and no record is lost or reordered.
// Reset: synchronous; clears the scan state (line 1, offset 0, no errors),
//   empties the buffer and restores error_limit to 10.
module source_tokenizer import stk_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic [15:0] error_limit_ff;
   logic        take;
   logic        push;
   logic        full;
   batch_type   push_batch;

   assign csr_ready = 1'b1;
   assign req_ready = !full;
   assign take      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         error_limit_ff <= ERROR_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         error_limit_ff <= csr_data;
      end
   end

   stk_scan #(
      .POSITION_BITS(POSITION_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .error_limit(error_limit_ff),
      .take       (take),
      .req_data   (req_data),
      .push       (push),
      .push_batch (push_batch)
   );

   stk_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_batch(push_batch),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_END |-> rsp_data.last_of_run)
      else $error("end record not last of its request");

   a_flags_only_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_END |-> !rsp_data.any_error && !rsp_data.aborted)
      else $error("error flags on a non-end record");

   a_error_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_SEMI_ERR || rsp_data.kind == KIND_CHAR_ERR ||
                    rsp_data.kind == KIND_FRAC_ERR || rsp_data.kind == KIND_UNTERM ||
                    rsp_data.kind == KIND_END) |-> rsp_data.lexeme_length == 32'd0)
      else $error("error or end record with nonzero length");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("buffer not empty after reset");
`endif

endmodule

### rtl/core/stk_scan.sv
module stk_scan import stk_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] error_limit,
   input  logic        take,
   input  req_type     req_data,
   output logic        push,
   output batch_type   push_batch
);

   localparam int NUM_CAND = 6;

   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;

   typedef enum logic [9:0] {
      MODE_IDLE    = 10'b00_0000_0001,
      MODE_COLON   = 10'b00_0000_0010,
      MODE_SEMI    = 10'b00_0000_0100,
      MODE_COMMENT = 10'b00_0000_1000,
      MODE_IDENT   = 10'b00_0001_0000,
      MODE_INT     = 10'b00_0010_0000,
      MODE_DOT     = 10'b00_0100_0000,
      MODE_FRAC    = 10'b00_1000_0000,
      MODE_STRING  = 10'b01_0000_0000,
      MODE_ABORTED = 10'b10_0000_0000
   } mode_type;

   typedef logic [POSITION_BITS-1:0] pos_type;

   mode_type    mode_ff, mode_in;
   pos_type     tstart_ff, tstart_in;
   pos_type     pos_ff, pos_in;
   logic [31:0] line_ff, line_in;
   logic [15:0] tally_ff, tally_in;
   logic        seen_ff, seen_in;

   rsp_type                   cand [NUM_CAND];
   logic [NUM_CAND-1:0]       cand_v;
   logic [REC_COUNT_BITS-1:0] cnt;
   logic [REC_COUNT_BITS-1:0] last_cnt;
   logic [7:0]                c;
   logic                      done;
   logic                      errs;
   pos_type                   pos_next;

   function automatic logic [31:0] out32(input pos_type p);
      logic [63:0] w;
      w = 64'(p);
      return w[31:0];
   endfunction

   function automatic rsp_type mk(input kind_type k, input pos_type start, input pos_type len,
                                  input logic [31:0] line, input logic anyerr,
                                  input logic abrt);
      rsp_type r;
      r.kind          = k;
      r.start_offset  = out32(start);
      r.lexeme_length = out32(len);
      r.line_number   = line;
      r.any_error     = anyerr;
      r.aborted       = abrt;
      r.last_of_run   = 1'b0;
      return r;
   endfunction

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return ch inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] ch);
      return ch inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   always_comb begin
      c         = req_data.char_code;
      mode_in   = mode_ff;
      tstart_in = tstart_ff;
      line_in   = line_ff;
      tally_in  = tally_ff;
      seen_in   = seen_ff;
      pos_next  = pos_ff + pos_type'(1);
      done      = (mode_ff == MODE_ABORTED);
      errs      = 1'b0;
      cand_v    = '0;
      for (int i = 0; i < NUM_CAND; i++) begin
         cand[i] = '0;
      end

      // close or extend the token in progress
      case (mode_ff)
         MODE_COLON: begin
            if (c == CH_COLON) begin
               cand[0] = mk(KIND_SCOPE, tstart_ff, pos_type'(2), line_ff, 1'b0, 1'b0);
               done = 1'b1;
            end else begin
               cand[0] = mk(KIND_COLON, tstart_ff, pos_type'(1), line_ff, 1'b0, 1'b0);
            end
            cand_v[0] = 1'b1;
            mode_in = MODE_IDLE;
         end
         MODE_SEMI: begin
            if (c == CH_SEMI) begin
               mode_in = MODE_COMMENT;
               done = 1'b1;
            end else begin
               cand[0] = mk(KIND_SEMI_ERR, tstart_ff, '0, line_ff, 1'b0, 1'b0);
               cand_v[0] = 1'b1;
               errs = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_COMMENT: begin
            if (c == CH_NL) mode_in = MODE_IDLE;
            else done = 1'b1;
         end
         MODE_IDENT: begin
            if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
               done = 1'b1;
            end else begin
               cand[0] = mk(KIND_IDENT, tstart_ff, pos_ff - tstart_ff, line_ff, 1'b0, 1'b0);
               cand_v[0] = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_INT: begin
            if (is_digit(c)) begin
               done = 1'b1;
            end else if (c == CH_DOT) begin
               mode_in = MODE_DOT;
               done = 1'b1;
            end else begin
               cand[0] = mk(KIND_NUMBER, tstart_ff, pos_ff - tstart_ff, line_ff, 1'b0, 1'b0);
               cand_v[0] = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_DOT: begin
            if (is_digit(c)) begin
               mode_in = MODE_FRAC;
               done = 1'b1;
            end else begin
               cand[0] = mk(KIND_FRAC_ERR, tstart_ff, '0, line_ff, 1'b0, 1'b0);
               cand[1] = mk(KIND_NUMBER, tstart_ff, pos_ff - tstart_ff, line_ff, 1'b0, 1'b0);
               cand_v[1:0] = 2'b11;
               errs = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_FRAC: begin
            if (is_digit(c)) begin
               done = 1'b1;
            end else begin
               cand[0] = mk(KIND_NUMBER, tstart_ff, pos_ff - tstart_ff, line_ff, 1'b0, 1'b0);
               cand_v[0] = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_STRING: begin
            if (c == CH_QUOTE) begin
               cand[0] = mk(KIND_STRING, tstart_ff, pos_ff - tstart_ff, line_ff, 1'b0, 1'b0);
               cand_v[0] = 1'b1;
               mode_in = MODE_IDLE;
            end
            done = 1'b1;
         end
         default: begin
         end
      endcase

      if (errs) begin
         tally_in = sat_inc(tally_in);
         seen_in  = 1'b1;
         if (tally_in > error_limit) begin
            mode_in = MODE_ABORTED;
            done = 1'b1;
         end
      end

      // byte seen in idle mode: start a new token, count a newline or flag a bad byte
      if (!done && mode_in == MODE_IDLE) begin
         case (c)
            CH_COLON: begin
               mode_in = MODE_COLON;
               tstart_in = pos_ff;
            end
            CH_PLUS: begin
               cand[2] = mk(KIND_PLUS, pos_ff, pos_type'(1), line_ff, 1'b0, 1'b0);
               cand_v[2] = 1'b1;
            end
            CH_MINUS: begin
               cand[2] = mk(KIND_MINUS, pos_ff, pos_type'(1), line_ff, 1'b0, 1'b0);
               cand_v[2] = 1'b1;
            end
            CH_STAR: begin
               cand[2] = mk(KIND_STAR, pos_ff, pos_type'(1), line_ff, 1'b0, 1'b0);
               cand_v[2] = 1'b1;
            end
            CH_SLASH: begin
               cand[2] = mk(KIND_SLASH, pos_ff, pos_type'(1), line_ff, 1'b0, 1'b0);
               cand_v[2] = 1'b1;
            end
            CH_LBRACK: begin
               cand[2] = mk(KIND_LBRACKET, pos_ff, pos_type'(1), line_ff, 1'b0, 1'b0);
               cand_v[2] = 1'b1;
            end
            CH_RBRACK: begin
               cand[2] = mk(KIND_RBRACKET, pos_ff, pos_type'(1), line_ff, 1'b0, 1'b0);
               cand_v[2] = 1'b1;
            end
            CH_QUOTE: begin
               mode_in = MODE_STRING;
               tstart_in = pos_next;
            end
            CH_SPACE, CH_TAB, CH_CR: begin
            end
            CH_NL: begin
               if (line_ff != 32'hFFFF_FFFF) line_in = line_ff + 32'd1;
            end
            CH_SEMI: begin
               mode_in = MODE_SEMI;
               tstart_in = pos_ff;
            end
            default: begin
               if (is_alpha(c) || c == CH_UNDER) begin
                  mode_in = MODE_IDENT;
                  tstart_in = pos_ff;
               end else if (is_digit(c)) begin
                  mode_in = MODE_INT;
                  tstart_in = pos_ff;
               end else begin
                  cand[2] = mk(KIND_CHAR_ERR, pos_ff, '0, line_ff, 1'b0, 1'b0);
                  cand_v[2] = 1'b1;
                  tally_in = sat_inc(tally_in);
                  seen_in = 1'b1;
                  if (tally_in > error_limit) mode_in = MODE_ABORTED;
               end
            end
         endcase
      end

      // end of file: flush the pending token, then the end record
      if (req_data.end_of_file) begin
         errs = 1'b0;
         case (mode_in)
            MODE_COLON: begin
               cand[3] = mk(KIND_COLON, tstart_in, pos_type'(1), line_in, 1'b0, 1'b0);
               cand_v[3] = 1'b1;
            end
            MODE_SEMI: begin
               cand[3] = mk(KIND_SEMI_ERR, tstart_in, '0, line_in, 1'b0, 1'b0);
               cand_v[3] = 1'b1;
               errs = 1'b1;
            end
            MODE_IDENT: begin
               cand[3] = mk(KIND_IDENT, tstart_in, pos_next - tstart_in, line_in, 1'b0, 1'b0);
               cand_v[3] = 1'b1;
            end
            MODE_INT, MODE_FRAC: begin
               cand[3] = mk(KIND_NUMBER, tstart_in, pos_next - tstart_in, line_in, 1'b0, 1'b0);
               cand_v[3] = 1'b1;
            end
            MODE_DOT: begin
               cand[3] = mk(KIND_FRAC_ERR, tstart_in, '0, line_in, 1'b0, 1'b0);
               cand[4] = mk(KIND_NUMBER, tstart_in, pos_next - tstart_in, line_in, 1'b0, 1'b0);
               cand_v[4:3] = 2'b11;
               errs = 1'b1;
            end
            MODE_STRING: begin
               cand[3] = mk(KIND_UNTERM, tstart_in, '0, line_in, 1'b0, 1'b0);
               cand_v[3] = 1'b1;
               errs = 1'b1;
            end
            default: begin
            end
         endcase
         if (errs) begin
            tally_in = sat_inc(tally_in);
            seen_in = 1'b1;
            if (tally_in > error_limit) mode_in = MODE_ABORTED;
         end
         cand[5] = mk(KIND_END, pos_next, '0, line_in, seen_in, mode_in == MODE_ABORTED);
         cand_v[5] = 1'b1;
         mode_in   = MODE_IDLE;
         tstart_in = '0;
         pos_next  = '0;
         line_in   = 32'd1;
         tally_in  = '0;
         seen_in   = 1'b0;
      end

      // pack records in order
      push_batch = '0;
      cnt = '0;
      for (int i = 0; i < NUM_CAND; i++) begin
         if (cand_v[i] && cnt < REC_COUNT_BITS'(RECS_PER_ITEM)) begin
            push_batch.rec[cnt[REC_INDEX_BITS-1:0]] = cand[i];
            cnt = cnt + REC_COUNT_BITS'(1);
         end
      end
      last_cnt = cnt - REC_COUNT_BITS'(1);
      if (cnt != '0) push_batch.rec[last_cnt[REC_INDEX_BITS-1:0]].last_of_run = 1'b1;
      push_batch.count = cnt;
      pos_in = pos_next;
   end

   assign push = take && (cnt != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         tstart_ff <= '0;
         pos_ff    <= '0;
         line_ff   <= 32'd1;
         tally_ff  <= '0;
         seen_ff   <= 1'b0;
      end else if (take) begin
         mode_ff   <= mode_in;
         tstart_ff <= tstart_in;
         pos_ff    <= pos_in;
         line_ff   <= line_in;
         tally_ff  <= tally_in;
         seen_ff   <= seen_in;
      end
   end

endmodule

### rtl/core/stk_rsp_queue.sv
module stk_rsp_queue import stk_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  batch_type push_batch,
   output logic      full,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   localparam int DEPTH = 2;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   batch_type                 slot_ff [DEPTH];
   logic [PTR_BITS-1:0]       wr_ff, wr_in;
   logic [PTR_BITS-1:0]       rd_ff, rd_in;
   logic [CNT_BITS-1:0]       count_ff, count_in;
   logic [REC_INDEX_BITS-1:0] idx_ff, idx_in;
   logic                      pop_rec;
   logic                      pop_batch;

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = slot_ff[rd_ff].rec[idx_ff];
   assign pop_rec   = rsp_valid && rsp_ready;
   assign pop_batch = pop_rec && rsp_data.last_of_run;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      if (push) wr_in = wr_ff + PTR_BITS'(1);
      if (pop_batch) begin
         rd_in  = rd_ff + PTR_BITS'(1);
         idx_in = '0;
      end else if (pop_rec) begin
         idx_in = idx_ff + REC_INDEX_BITS'(1);
      end
      if (push && !pop_batch) count_in = count_ff + CNT_BITS'(1);
      else if (!push && pop_batch) count_in = count_ff - CNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         idx_ff   <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_batch;
   end

endmodule
